// ===== hw/rtl/lcc_pkg.sv =====
// lcc_pkg: shared constants for the local clustering coefficient engine
// operation codes, status codes, register indexes, field widths and defaults
// no dependencies
package lcc_pkg;

  // default sizing
  localparam int NODES_DEF  = 64;
  localparam int MAXDEG_DEF = 16;

  // field widths
  localparam int FUNC_W   = 2;
  localparam int NODE_W   = 6;
  localparam int COEF_W   = 17;
  localparam int STATUS_W = 2;
  localparam int CNT_CFG_W = 7;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 7;
  localparam int FRAC_W   = 16;

  localparam logic [COEF_W-1:0] Q_ONE = 17'd65536;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_AVG    = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTED   = 1'd1;

endpackage

// ===== hw/rtl/lcc_div.sv =====
// lcc_div: restoring divider, one quotient bit per cycle
// shared by node coefficient and average computation; no package needed
module lcc_div #(
  parameter int NW = 28,
  parameter int DW = 12
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] rem_r, rem_nxt;
  logic [NW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [DW:0]   trial;

  // one trial subtraction per cycle
  always_comb begin
    trial = {rem_r, quo_r[NW-1]} - {1'b0, den_r};
    if (!trial[DW]) begin
      rem_nxt = trial[DW-1:0];
      quo_nxt = {quo_r[NW-2:0], 1'b1};
    end else begin
      rem_nxt = {rem_r[DW-2:0], quo_r[NW-1]};
      quo_nxt = {quo_r[NW-2:0], 1'b0};
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ===== hw/rtl/local_clustering_coefficient.sv =====
// local_clustering_coefficient: top level, list memories and pair-walk sequencer
// depends on lcc_pkg and lcc_div
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall   | func, node, neighbor
//   out_    | output    | out_valid/out_stall | coefficient, status
//   cfg_    | input     | cfg_valid/cfg_ready | index, data
//
// clear goes straight to the output state, append through S_APP when in range;
// a node query walks each neighbor pair via S_A, S_B, S_D and S_L, scanning the
// first neighbor's list in S_CMP, then uses the shared divider (NW = 24 by default)
// the average repeats the node walk for every node and divides once more
// reset is synchronous and empties all lists at once through per-node valid bits
// in_stall stays high for the whole transaction; a stalled result holds the
// sequencer in its output state until taken
module local_clustering_coefficient
  import lcc_pkg::*;
#(
  parameter int NODES      = NODES_DEF,
  parameter int MAX_DEGREE = MAXDEG_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lcc_pkg::FUNC_W-1:0]    in_func,
  input  logic [lcc_pkg::NODE_W-1:0]    in_node,
  input  logic [lcc_pkg::NODE_W-1:0]    in_neighbor,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lcc_pkg::COEF_W-1:0]    out_coefficient,
  output logic [lcc_pkg::STATUS_W-1:0]  out_status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lcc_pkg::CFG_DAT_W-1:0] cfg_data
);

  localparam int NAW   = $clog2(NODES);
  localparam int SAW   = $clog2(NODES * MAX_DEGREE);
  localparam int DGW   = $clog2(MAX_DEGREE + 1);
  localparam int CNTW  = $clog2(MAX_DEGREE * (MAX_DEGREE - 1) + 1);
  localparam int SUMW  = $clog2(NODES * 65536 + 1);
  localparam int NW    = (CNTW + FRAC_W > SUMW) ? CNTW + FRAC_W : SUMW;
  localparam int DW    = (CNTW > CNT_CFG_W) ? CNTW : CNT_CFG_W;
  localparam int LW    = CNT_CFG_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_APP  = 4'd1;
  localparam logic [3:0] S_KRD  = 4'd2;
  localparam logic [3:0] S_K    = 4'd3;
  localparam logic [3:0] S_A    = 4'd4;
  localparam logic [3:0] S_B    = 4'd5;
  localparam logic [3:0] S_D    = 4'd6;
  localparam logic [3:0] S_L    = 4'd7;
  localparam logic [3:0] S_CMP  = 4'd8;
  localparam logic [3:0] S_DIV  = 4'd9;
  localparam logic [3:0] S_DIVW = 4'd10;
  localparam logic [3:0] S_NEXT = 4'd11;
  localparam logic [3:0] S_AVGW = 4'd12;
  localparam logic [3:0] S_OUT  = 4'd13;

  // configuration
  logic [LW-1:0] node_count_r;
  logic          directed_r;
  logic [LW-1:0] lim;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= LW'(64);
      directed_r   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_NODE_COUNT: node_count_r <= cfg_data;
        REG_DIRECTED:   directed_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;
  assign lim = (32'(node_count_r) < NODES) ? node_count_r : LW'(NODES);

  // sequencer registers
  logic [3:0]            state_r;
  logic [FUNC_W-1:0]     func_r;
  logic [NAW-1:0]        node_r;
  logic [NODE_W-1:0]     nb_r;
  logic [LW-1:0]         cur_r;
  logic [DGW-1:0]        k_r, i_r, j_r, s_r, da_r;
  logic [NODE_W-1:0]     a_r, b_r;
  logic [CNTW-1:0]       cnt_r;
  logic [COEF_W-1:0]     nq_r;
  logic [SUMW-1:0]       sum_r;
  logic [COEF_W-1:0]     res_coef_r;
  logic [STATUS_W-1:0]   res_status_r;
  logic                  out_valid_r;
  logic [COEF_W-1:0]     out_coef_r;
  logic [STATUS_W-1:0]   out_status_r;

  // memories
  logic [DGW-1:0]    deg_mem [NODES];
  logic [NODES-1:0]  vld_r;
  logic [NODE_W-1:0] st_mem [NODES * MAX_DEGREE];
  logic [NAW-1:0]    deg_raddr;
  logic [DGW-1:0]    deg_q_r;
  logic              deg_vq_r;
  logic [DGW-1:0]    deg_val;
  logic [SAW-1:0]    st_raddr;
  logic [NODE_W-1:0] st_q_r;
  logic              deg_we;
  logic [DGW-1:0]    deg_wdata;
  logic [SAW-1:0]    st_waddr;

  // divider
  logic          div_start, div_busy, div_done;
  logic [NW-1:0] div_num, div_quo;
  logic [DW-1:0] div_den;
  logic [2*DGW-1:0] kk;

  // pair stepping
  logic [DGW:0] j1, i1;
  logic         row_end, walk_end;

  logic in_acc;
  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign deg_val  = deg_vq_r ? deg_q_r : '0;

  // read address selection
  always_comb begin
    unique case (state_r)
      S_IDLE:  deg_raddr = NAW'(in_node);
      S_D:     deg_raddr = NAW'(a_r);
      default: deg_raddr = NAW'(cur_r);
    endcase
    unique case (state_r)
      S_A:     st_raddr = SAW'(cur_r) * SAW'(MAX_DEGREE) + SAW'(i_r);
      S_B:     st_raddr = SAW'(cur_r) * SAW'(MAX_DEGREE) + SAW'(j_r);
      S_L:     st_raddr = SAW'(a_r) * SAW'(MAX_DEGREE);
      S_CMP:   st_raddr = SAW'(a_r) * SAW'(MAX_DEGREE) + SAW'(s_r) + SAW'(1);
      default: st_raddr = '0;
    endcase
  end

  // next pair: skip the self pair in directed mode
  always_comb begin
    j1 = {1'b0, j_r} + 1'b1;
    if (directed_r && j1 == {1'b0, i_r}) begin
      j1 = {1'b0, j_r} + 2'd2;
    end
    i1       = {1'b0, i_r} + 1'b1;
    row_end  = (j1 >= {1'b0, k_r});
    walk_end = (i1 >= {1'b0, k_r}) || (!directed_r && (i1 + 1'b1 >= {1'b0, k_r}));
  end

  // divider operands
  assign kk        = (2*DGW)'(k_r) * (2*DGW)'(k_r - 1'b1);
  assign div_start = (state_r == S_DIV) || (state_r == S_NEXT && func_r == FUNC_AVG &&
                     cur_r + 1'b1 == lim);
  always_comb begin
    if (state_r == S_NEXT) begin
      div_num = NW'(sum_r) + NW'(nq_r);
      div_den = DW'(lim);
    end else begin
      div_num = NW'(cnt_r) << FRAC_W;
      div_den = directed_r ? DW'(kk) : DW'(kk >> 1);
    end
  end

  lcc_div #(.NW(NW), .DW(DW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  // append write port
  assign deg_we    = (state_r == S_APP) && (deg_val < DGW'(MAX_DEGREE));
  assign deg_wdata = deg_val + 1'b1;
  assign st_waddr  = SAW'(node_r) * SAW'(MAX_DEGREE) + SAW'(deg_val);

  // degree memory with registered read
  always_ff @(posedge clk) begin
    if (deg_we) begin
      deg_mem[node_r] <= deg_wdata;
    end
    deg_q_r <= deg_mem[deg_raddr];
  end

  // neighbor memory with registered read
  always_ff @(posedge clk) begin
    if (deg_we) begin
      st_mem[st_waddr] <= nb_r;
    end
    st_q_r <= st_mem[st_raddr];
  end

  // per-node valid bits, emptied on reset and clear
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      deg_vq_r <= 1'b0;
    end else begin
      deg_vq_r <= vld_r[deg_raddr];
      if (in_acc && in_func == FUNC_CLEAR) begin
        vld_r <= '0;
      end else if (deg_we) begin
        vld_r[node_r] <= 1'b1;
      end
    end
  end

  // sequencer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // result register: load from the output state, drop once taken
      if (state_r == S_OUT && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            case (in_func)
              FUNC_CLEAR:  state_r <= S_OUT;
              FUNC_APPEND: begin
                if ({1'b0, in_node} >= lim || {1'b0, in_neighbor} >= lim) begin
                  state_r <= S_OUT;
                end else begin
                  state_r <= S_APP;
                end
              end
              FUNC_QUERY: begin
                state_r <= ({1'b0, in_node} >= lim) ? S_OUT : S_KRD;
              end
              default: begin
                state_r <= (lim == '0) ? S_OUT : S_KRD;
              end
            endcase
          end
        end
        S_APP:  state_r <= S_OUT;
        S_KRD:  state_r <= S_K;
        S_K:    state_r <= (deg_val < DGW'(2)) ? S_NEXT : S_A;
        S_A:    state_r <= S_B;
        S_B:    state_r <= S_D;
        S_D:    state_r <= S_L;
        S_L: begin
          if (deg_val == '0) begin
            state_r <= (row_end && walk_end) ? S_DIV : S_A;
          end else begin
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          if (st_q_r == b_r || {1'b0, s_r} + 1'b1 == {1'b0, da_r}) begin
            state_r <= (row_end && walk_end) ? S_DIV : S_A;
          end
        end
        S_DIV:  state_r <= S_DIVW;
        S_DIVW: if (div_done) state_r <= S_NEXT;
        S_NEXT: begin
          if (func_r == FUNC_QUERY) begin
            state_r <= S_OUT;
          end else if (cur_r + 1'b1 == lim) begin
            state_r <= S_AVGW;
          end else begin
            state_r <= S_KRD;
          end
        end
        S_AVGW: if (div_done) state_r <= S_OUT;
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        func_r       <= in_func;
        node_r       <= NAW'(in_node);
        nb_r         <= in_neighbor;
        cur_r        <= (in_func == FUNC_AVG) ? '0 : LW'(in_node);
        sum_r        <= '0;
        res_coef_r   <= '0;
        res_status_r <= ST_OK;
        if ((in_func == FUNC_APPEND &&
             ({1'b0, in_node} >= lim || {1'b0, in_neighbor} >= lim)) ||
            (in_func == FUNC_QUERY && {1'b0, in_node} >= lim)) begin
          res_status_r <= ST_RANGE;
        end
      end
      S_APP: begin
        if (deg_val >= DGW'(MAX_DEGREE)) begin
          res_status_r <= ST_FULL;
        end
      end
      S_K: begin
        k_r   <= deg_val;
        i_r   <= '0;
        j_r   <= DGW'(1);
        cnt_r <= '0;
        nq_r  <= '0;
      end
      S_B: a_r <= st_q_r;
      S_D: b_r <= st_q_r;
      S_L: begin
        s_r  <= '0;
        da_r <= deg_val;
        if (deg_val == '0 && !(row_end && walk_end)) begin
          if (!row_end) begin
            j_r <= DGW'(j1);
          end else begin
            i_r <= DGW'(i1);
            j_r <= directed_r ? '0 : DGW'(i1 + 1'b1);
          end
        end
      end
      S_CMP: begin
        if (st_q_r == b_r || {1'b0, s_r} + 1'b1 == {1'b0, da_r}) begin
          if (st_q_r == b_r) begin
            cnt_r <= cnt_r + 1'b1;
          end
          if (!(row_end && walk_end)) begin
            if (!row_end) begin
              j_r <= DGW'(j1);
            end else begin
              i_r <= DGW'(i1);
              j_r <= directed_r ? '0 : DGW'(i1 + 1'b1);
            end
          end
        end else begin
          s_r <= s_r + 1'b1;
        end
      end
      S_DIVW: if (div_done) nq_r <= div_quo[COEF_W-1:0];
      S_NEXT: begin
        sum_r      <= sum_r + SUMW'(nq_r);
        cur_r      <= cur_r + 1'b1;
        res_coef_r <= nq_r;
      end
      S_AVGW: if (div_done) res_coef_r <= div_quo[COEF_W-1:0];
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_coef_r   <= res_coef_r;
          out_status_r <= res_status_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_coefficient = out_coef_r;
  assign out_status      = out_status_r;

  // checks
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy) else $error("divider restarted while busy");
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT)) else $error("result from wrong state");
  a_coef_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_coef_r <= Q_ONE) else $error("coefficient above one");
  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> out_coef_r == '0)
    else $error("flagged result with nonzero coefficient");
  a_deg_max: assert property (@(posedge clk) disable iff (!rst_n)
    deg_we |-> deg_wdata <= DGW'(MAX_DEGREE)) else $error("degree overflow");

endmodule

// ===== tb/local_clustering_coefficient_tb.sv =====
// testbench for local_clustering_coefficient: directed and random transactions
// checked against a scoreboard that keeps its own copy of the neighbor lists
// depends on lcc_pkg and the local_clustering_coefficient rtl
`timescale 1ns / 1ps

class lcc_scoreboard;
  localparam int NODES  = 64;
  localparam int MAXDEG = 16;

  int unsigned nodes_used;
  bit          directed;
  int unsigned degree[NODES];
  int unsigned adj[NODES*MAXDEG];
  logic [16:0] exp_coef[$];
  logic [1:0]  exp_status[$];
  int          mismatches;

  function new();
    nodes_used = 64;
    directed   = 0;
    mismatches = 0;
    foreach (degree[i]) degree[i] = 0;
  endfunction

  function int unsigned limit_nodes();
    return (nodes_used < NODES) ? nodes_used : NODES;
  endfunction

  function bit linked(int unsigned from, int unsigned to);
    for (int unsigned s = 0; s < degree[from] && s < MAXDEG; s++)
      if (adj[from*MAXDEG + s] == to) return 1;
    return 0;
  endfunction

  // truncated q1.16 coefficient of one node
  function longint unsigned node_coef(int unsigned n);
    int unsigned k;
    longint unsigned links;
    longint unsigned denom;
    links = 0;
    k = (degree[n] > MAXDEG) ? MAXDEG : degree[n];
    if (k < 2) return 0;
    for (int unsigned i = 0; i < k; i++)
      for (int unsigned j = directed ? 0 : i + 1; j < k; j++)
        if (i != j && linked(adj[n*MAXDEG + i], adj[n*MAXDEG + j])) links++;
    denom = longint'(k) * longint'(k - 1);
    if (!directed) denom = denom >> 1;
    return (links << 16) / denom;
  endfunction

  function void write_reg(logic idx, logic [6:0] data);
    if (idx == lcc_pkg::REG_NODE_COUNT) nodes_used = data;
    else directed = data[0];
  endfunction

  // accepted input transaction: update lists and queue its result
  function void note_input(logic [1:0] f, logic [5:0] n, logic [5:0] nb);
    int unsigned lim;
    longint unsigned coef;
    longint unsigned sum;
    logic [1:0] st;
    lim  = limit_nodes();
    coef = 0;
    st   = lcc_pkg::ST_OK;
    case (f)
      lcc_pkg::FUNC_CLEAR: begin
        foreach (degree[i]) degree[i] = 0;
      end
      lcc_pkg::FUNC_APPEND: begin
        if (n >= lim || nb >= lim) st = lcc_pkg::ST_RANGE;
        else if (degree[n] >= MAXDEG) st = lcc_pkg::ST_FULL;
        else begin
          adj[n*MAXDEG + degree[n]] = nb;
          degree[n]++;
        end
      end
      lcc_pkg::FUNC_QUERY: begin
        if (n >= lim) st = lcc_pkg::ST_RANGE;
        else coef = node_coef(n);
      end
      default: begin
        sum = 0;
        for (int unsigned i = 0; i < lim; i++) sum += node_coef(i);
        coef = lim ? sum / lim : 0;
      end
    endcase
    exp_coef.push_back(coef[16:0]);
    exp_status.push_back(st);
  endfunction

  function void check_result(logic [16:0] coef, logic [1:0] st);
    logic [16:0] ec;
    logic [1:0]  es;
    if (exp_coef.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result coef=%0d status=%0d", coef, st);
      return;
    end
    ec = exp_coef.pop_front();
    es = exp_status.pop_front();
    if (coef !== ec || st !== es) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: coef exp %0d got %0d, status exp %0d got %0d", ec, coef, es, st);
    end
  endfunction

  function int pending();
    return exp_coef.size();
  endfunction
endclass

module local_clustering_coefficient_tb;
  import lcc_pkg::*;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [FUNC_W-1:0] in_func;
  logic [NODE_W-1:0] in_node;
  logic [NODE_W-1:0] in_neighbor;
  logic out_valid;
  logic out_stall;
  logic [COEF_W-1:0] out_coefficient;
  logic [STATUS_W-1:0] out_status;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  lcc_scoreboard sb;
  int unsigned cycles;
  int unsigned burst_left;
  bit          hold_req;
  int unsigned hold_left;
  int unsigned stall_pct;

  local_clustering_coefficient dut (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 4000000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // monitors for accepted transactions on both channels
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_input(in_func, in_node, in_neighbor);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_coefficient, out_status);
  end

  // receiver stall pattern, with a long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req  <= 0;
      hold_left <= 3000;
      out_stall <= 1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1;
    end else begin
      if ($urandom_range(0, 199) == 0) stall_pct <= $urandom_range(0, 2) * 40;
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic send_item(logic [1:0] f, logic [5:0] n, logic [5:0] nb);
    // bursts of transactions separated by random gaps
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_valid    <= 1;
    in_func     <= f;
    in_node     <= n;
    in_neighbor <= nb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // let the monitor note the last accepted transaction before checking what is pending
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [6:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // random transaction mix: mostly appends and queries on in-range nodes
  task automatic random_item();
    int unsigned lim;
    int unsigned r;
    logic [1:0] f;
    logic [5:0] n;
    logic [5:0] nb;
    lim = sb.limit_nodes();
    r = $urandom_range(0, 99);
    if (r < 5) f = FUNC_CLEAR;
    else if (r < 65) f = FUNC_APPEND;
    else if (r < 92) f = FUNC_QUERY;
    else f = FUNC_AVG;
    if (lim > 0 && $urandom_range(0, 9) != 0) begin
      n  = $urandom_range(0, lim - 1);
      nb = $urandom_range(0, lim - 1);
    end else begin
      n  = $urandom_range(0, 63);
      nb = $urandom_range(0, 63);
    end
    send_item(f, n, nb);
  endtask

  task automatic phase(int unsigned count, logic [6:0] nodes, bit dir);
    drain();
    write_cfg(REG_NODE_COUNT, nodes);
    write_cfg(REG_DIRECTED, {6'd0, dir});
    repeat (count) random_item();
  endtask

  initial begin
    sb = new();
    cycles = 0;
    burst_left = 0;
    hold_req = 0;
    hold_left = 0;
    stall_pct = 0;
    rst_n = 0;
    in_valid = 0;
    in_func = FUNC_CLEAR;
    in_node = 0;
    in_neighbor = 0;
    out_stall = 0;
    cfg_valid = 0;
    cfg_index = REG_NODE_COUNT;
    cfg_data = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: triangle, extremes, self loop, duplicates, full list, range
    send_item(FUNC_QUERY, 6'd0, 6'd0);
    send_item(FUNC_APPEND, 6'd0, 6'd1);
    send_item(FUNC_APPEND, 6'd0, 6'd2);
    send_item(FUNC_APPEND, 6'd1, 6'd2);
    send_item(FUNC_QUERY, 6'd0, 6'd0);
    send_item(FUNC_APPEND, 6'd63, 6'd0);
    send_item(FUNC_APPEND, 6'd63, 6'd63);
    send_item(FUNC_APPEND, 6'd63, 6'd0);
    send_item(FUNC_QUERY, 6'd63, 6'd63);
    send_item(FUNC_AVG, 6'd0, 6'd0);
    for (int i = 0; i < 17; i++) send_item(FUNC_APPEND, 6'd5, 6'(i % 3));
    send_item(FUNC_QUERY, 6'd5, 6'd0);
    drain();
    write_cfg(REG_DIRECTED, 7'd1);
    send_item(FUNC_QUERY, 6'd5, 6'd0);
    send_item(FUNC_AVG, 6'd0, 6'd0);
    drain();
    write_cfg(REG_NODE_COUNT, 7'd3);
    send_item(FUNC_APPEND, 6'd63, 6'd1);
    send_item(FUNC_QUERY, 6'd63, 6'd0);
    send_item(FUNC_AVG, 6'd0, 6'd0);
    send_item(FUNC_CLEAR, 6'd0, 6'd0);

    // register settings sweep, extremes included
    phase(70, 7'd64, 1'b0);
    phase(70, 7'd64, 1'b1);
    phase(40, 7'd1, 1'b0);
    phase(40, 7'd2, 1'b1);
    phase(20, 7'd0, 1'b0);
    phase(40, 7'd127, 1'b1);
    phase(60, 7'd6, 1'b0);

    // long receiver hold-off while the sender keeps offering
    drain();
    write_cfg(REG_NODE_COUNT, 7'd8);
    write_cfg(REG_DIRECTED, 7'd1);
    hold_req <= 1;
    repeat (50) random_item();
    // sender pause until everything has come back, then more traffic
    drain();
    repeat (40) random_item();
    phase(30, 7'd16, 1'b0);

    drain();
    repeat (200) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
